// ----- hw/rtl/ppil_pkg.sv -----
// ----------------------------------------------------------------------------
// ppil_pkg: shared types for the plane-plane intersection line block
// Request payload structs, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ppil_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INTERSECT = 2'd0,
    ST_PARALLEL  = 2'd1,
    ST_SINGULAR  = 2'd2
  } status_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_THR = 1'b1;

  // Reset value of both thresholds
  localparam logic [CFG_DATA_W-1:0] THR_RESET = 31'd1;

  // Input request: two planes n.p + d = 0, signed fixed point
  typedef struct packed {
    logic signed [31:0] first_nx;
    logic signed [31:0] first_ny;
    logic signed [31:0] first_nz;
    logic signed [31:0] first_offset;
    logic signed [31:0] second_nx;
    logic signed [31:0] second_ny;
    logic signed [31:0] second_nz;
    logic signed [31:0] second_offset;
    logic               want_line;
  } in_t;

  // Result request: status, direction and point on the line
  typedef struct packed {
    status_t            status;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_t;

endpackage

// ----- hw/rtl/ppil_mul.sv -----
// ----------------------------------------------------------------------------
// ppil_mul: pipelined wide signed multiplier
// Splits magnitudes into 32-bit digits, forms partial products, sums them and
// restores the sign.
// ----------------------------------------------------------------------------
module ppil_mul #(
  parameter int AW = 48,
  parameter int BW = 48
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CA = (AW + 31) / 32;
  localparam int CB = (BW + 31) / 32;
  localparam int PWID = AW + BW;

  logic [AW-1:0]      amag;
  logic [BW-1:0]      bmag;
  logic [CA*32-1:0]   ma_r;
  logic [CB*32-1:0]   mb_r;
  logic               neg1_r, neg2_r, neg3_r;
  logic [63:0]        pp_r [CA][CB];
  logic [PWID-1:0]    acc;
  logic [PWID-1:0]    sum_r;
  logic signed [PWID-1:0] p_r;

  // Take magnitudes
  assign amag = a[AW-1] ? AW'(-a) : AW'(a);
  assign bmag = b[BW-1] ? BW'(-b) : BW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= (CA*32)'(amag);
      mb_r   <= (CB*32)'(bmag);
      neg1_r <= a[AW-1] ^ b[BW-1];
    end
  end

  // Form 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CA; i++) begin
        for (int j = 0; j < CB; j++) begin
          pp_r[i][j] <= ma_r[i*32 +: 32] * mb_r[j*32 +: 32];
        end
      end
      neg2_r <= neg1_r;
    end
  end

  // Sum shifted partial products
  always_comb begin
    acc = '0;
    for (int i = 0; i < CA; i++) begin
      for (int j = 0; j < CB; j++) begin
        acc = acc + (PWID'(pp_r[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= acc;
      neg3_r <= neg2_r;
    end
  end

  // Restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg3_r ? PWID'(-sum_r) : sum_r;
    end
  end

  assign p = p_r;

endmodule

// ----- hw/rtl/ppil_div.sv -----
// ----------------------------------------------------------------------------
// ppil_div: pipelined restoring divider with quotient overflow flag
// One quotient bit per stage. Flags quotients of 2^QB or more.
// ----------------------------------------------------------------------------
module ppil_div #(
  parameter int NUMW = 133,
  parameter int DENW = 102,
  parameter int QB   = 31
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QB-1:0]   quo,
  output logic            ovf
);

  logic [NUMW-1:0] r_r [QB];
  logic [DENW-1:0] d_r [QB];
  logic [QB-1:0]   q_r [QB+1];
  logic            o_r [QB+1];

  // Load and check for quotient overflow
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= num;
      d_r[0] <= den;
      q_r[0] <= '0;
      o_r[0] <= num >= (NUMW'(den) << QB);
    end
  end

  // One trial subtraction per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int SH = QB - k;
    logic [NUMW:0] trial;
    assign trial = {1'b0, r_r[k-1]} - {1'b0, NUMW'(d_r[k-1]) << SH};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_r[k-1] | (trial[NUMW] ? QB'(0) : (QB'(1) << SH));
        o_r[k] <= o_r[k-1];
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k] <= trial[NUMW] ? r_r[k-1] : trial[NUMW-1:0];
          d_r[k] <= d_r[k-1];
        end
      end
    end
  end

  assign quo = q_r[QB];
  assign ovf = o_r[QB];

endmodule

// ----- hw/rtl/plane_plane_intersection_line.sv -----
// ----------------------------------------------------------------------------
// plane_plane_intersection_line: line where two planes meet
// Cross product direction, parallel and singular tests, point on both planes.
// ----------------------------------------------------------------------------
// One plane pair enters per cycle while in_ready is high, and each yields one
// result. A pair passes through eleven arithmetic stages (32x32 products,
// roundings, wide multipliers for the Gram determinant and point numerators),
// then a 32-stage quotient pipeline with a load stage and then one quotient
// bit per stage, then a two-entry output buffer. in_ready drops
// only while both buffer entries hold results that are not yet taken.
// Thresholds must be written while no request is in flight.
module plane_plane_intersection_line #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ppil_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ppil_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [ppil_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppil_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int F    = FRAC_BITS;
  localparam int NW   = 66 - F;
  localparam int DW   = 2 * NW + 1;
  localparam int MW   = 66;
  localparam int PW   = NW + MW + 2;
  localparam int NUMW = (PW + 2 > DW + 32) ? PW + 2 : DW + 32;
  localparam int DENW = DW + 1;
  localparam int QB   = 31;
  localparam int LD   = QB + 1;
  localparam logic [65:0] HALF = 66'(1) << (F - 1);

  typedef struct packed {
    logic                     want;
    logic                     par;
    logic signed [2:0][31:0]  dir;
  } side_t;

  typedef struct packed {
    side_t      sd;
    logic       sing;
    logic [2:0] neg;
  } tail_t;

  logic en;

  // Round at F fraction bits and saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] c);
    logic signed [65:0]   t;
    logic signed [65-F:0] sh;
    t  = c + HALF;
    sh = (66 - F)'(t >>> F);
    if (!sh[65-F] && (|sh[64-F:31])) begin
      return 32'sh7fffffff;
    end else if (sh[65-F] && !(&sh[64-F:31])) begin
      return 32'sh80000000;
    end
    return sh[31:0];
  endfunction

  // Configuration registers
  logic [ppil_pkg::CFG_DATA_W-1:0] thr_par_r, thr_sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_par_r  <= ppil_pkg::THR_RESET;
      thr_sing_r <= ppil_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppil_pkg::REG_PARALLEL_THR: thr_par_r  <= cfg_wdata;
        ppil_pkg::REG_SINGULAR_THR: thr_sing_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;
  logic vt_r [LD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r} <= '0;
      for (int i = 0; i < LD; i++) vt_r[i] <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      vt_r[0] <= v11_r;
      for (int i = 1; i < LD; i++) vt_r[i] <= vt_r[i-1];
    end
  end

  // Stage 1: capture request
  ppil_pkg::in_t x1_r;

  always_ff @(posedge clk) begin
    if (en) x1_r <= in_data;
  end

  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];

  assign a1[0] = x1_r.first_nx;
  assign a1[1] = x1_r.first_ny;
  assign a1[2] = x1_r.first_nz;
  assign b1[0] = x1_r.second_nx;
  assign b1[1] = x1_r.second_ny;
  assign b1[2] = x1_r.second_nz;

  // Stage 2: all 32x32 products
  logic signed [63:0] cr_r [6];
  logic signed [63:0] aa_r [3], ab_r [3], bb_r [3];
  logic signed [63:0] daa_r [3], dbb_r [3], dba_r [3], dab_r [3];
  logic               want2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= a1[1] * b1[2];
      cr_r[1] <= a1[2] * b1[1];
      cr_r[2] <= a1[2] * b1[0];
      cr_r[3] <= a1[0] * b1[2];
      cr_r[4] <= a1[0] * b1[1];
      cr_r[5] <= a1[1] * b1[0];
      for (int k = 0; k < 3; k++) begin
        aa_r[k]  <= a1[k] * a1[k];
        ab_r[k]  <= a1[k] * b1[k];
        bb_r[k]  <= b1[k] * b1[k];
        daa_r[k] <= x1_r.first_offset * a1[k];
        dbb_r[k] <= x1_r.second_offset * b1[k];
        dba_r[k] <= x1_r.second_offset * a1[k];
        dab_r[k] <= x1_r.first_offset * b1[k];
      end
      want2_r <= x1_r.want_line;
    end
  end

  // Stage 3: cross differences, dot sums, mixed offset terms
  logic signed [64:0] c3_r [3];
  logic signed [65:0] s00_3_r, s01_3_r, s11_3_r;
  logic signed [65:0] mix3_r [3];
  logic signed [63:0] daa3_r [3], dbb3_r [3];
  logic               want3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c3_r[k]   <= 65'(cr_r[2*k]) - 65'(cr_r[2*k+1]);
        mix3_r[k] <= 66'(dba_r[k]) + 66'(dab_r[k]);
        daa3_r[k] <= daa_r[k];
        dbb3_r[k] <= dbb_r[k];
      end
      s00_3_r <= 66'(aa_r[0]) + 66'(aa_r[1]) + 66'(aa_r[2]);
      s01_3_r <= 66'(ab_r[0]) + 66'(ab_r[1]) + 66'(ab_r[2]);
      s11_3_r <= 66'(bb_r[0]) + 66'(bb_r[1]) + 66'(bb_r[2]);
      want3_r <= want2_r;
    end
  end

  // Stage 4: round direction and Gram entries
  logic signed [NW-1:0] n00_4_r, n01_4_r, n11_4_r;
  logic signed [65:0]   mix4_r [3];
  logic signed [63:0]   daa4_r [3], dbb4_r [3];
  side_t                sd4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sd4_r.dir[k] <= round_sat(66'(c3_r[k]));
        mix4_r[k]    <= mix3_r[k];
        daa4_r[k]    <= daa3_r[k];
        dbb4_r[k]    <= dbb3_r[k];
      end
      n00_4_r    <= NW'((s00_3_r + HALF) >>> F);
      n01_4_r    <= NW'((s01_3_r + HALF) >>> F);
      n11_4_r    <= NW'((s11_3_r + HALF) >>> F);
      sd4_r.want <= want3_r;
      sd4_r.par  <= 1'b0;
    end
  end

  // Wide products for determinant and point numerators
  logic signed [2*NW-1:0]  m_nn, m_oo;
  logic signed [NW+MW-1:0] m_mix [3];
  logic signed [NW+63:0]   m_a [3], m_b [3];

  ppil_mul #(.AW(NW), .BW(NW)) u_mul_nn (
    .clk(clk), .en(en), .a(n00_4_r), .b(n11_4_r), .p(m_nn)
  );
  ppil_mul #(.AW(NW), .BW(NW)) u_mul_oo (
    .clk(clk), .en(en), .a(n01_4_r), .b(n01_4_r), .p(m_oo)
  );

  for (genvar k = 0; k < 3; k++) begin : g_pmul
    ppil_mul #(.AW(NW), .BW(MW)) u_mul_mix (
      .clk(clk), .en(en), .a(n01_4_r), .b(mix4_r[k]), .p(m_mix[k])
    );
    ppil_mul #(.AW(NW), .BW(64)) u_mul_a (
      .clk(clk), .en(en), .a(n11_4_r), .b(daa4_r[k]), .p(m_a[k])
    );
    ppil_mul #(.AW(NW), .BW(64)) u_mul_b (
      .clk(clk), .en(en), .a(n00_4_r), .b(dbb4_r[k]), .p(m_b[k])
    );
  end

  // Stage 5: squared direction magnitudes
  logic [31:0] dmag [3];
  logic [63:0] sqm5_r [3];
  side_t       sd5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k] = sd4_r.dir[k][31] ? 32'(-sd4_r.dir[k]) : 32'(sd4_r.dir[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) sqm5_r[k] <= dmag[k] * dmag[k];
      sd5_r <= sd4_r;
    end
  end

  // Stage 6: parallel test
  logic [63:0] sq_len;
  side_t       sd6_nxt;
  side_t       sd6_r, sd7_r, sd8_r;

  assign sq_len = sqm5_r[0] + sqm5_r[1] + sqm5_r[2];

  always_comb begin
    sd6_nxt     = sd5_r;
    sd6_nxt.par = sq_len < (64'(thr_par_r) << F);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd6_r <= sd6_nxt;
      sd7_r <= sd6_r;
      sd8_r <= sd7_r;
    end
  end

  // Stage 9: determinant and point numerators
  logic signed [DW-1:0] det9_r;
  logic signed [PW-1:0] p9_r [3];
  side_t                sd9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det9_r <= DW'(m_nn) - DW'(m_oo);
      for (int k = 0; k < 3; k++) begin
        p9_r[k] <= PW'(m_mix[k]) - PW'(m_a[k]) - PW'(m_b[k]);
      end
      sd9_r <= sd8_r;
    end
  end

  // Stage 10: magnitudes and quotient signs
  logic [DW-1:0] adet10_r;
  logic [PW-1:0] ap10_r [3];
  logic [2:0]    neg10_r;
  side_t         sd10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      adet10_r <= det9_r[DW-1] ? DW'(-det9_r) : DW'(det9_r);
      for (int k = 0; k < 3; k++) begin
        ap10_r[k]  <= p9_r[k][PW-1] ? PW'(-p9_r[k]) : PW'(p9_r[k]);
        neg10_r[k] <= p9_r[k][PW-1] ^ det9_r[DW-1];
      end
      sd10_r <= sd9_r;
    end
  end

  // Stage 11: rounded-quotient operands and singular test
  logic [NUMW-1:0] num11_r [3];
  logic [DENW-1:0] den11_r;
  tail_t           tl11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num11_r[k] <= (NUMW'(ap10_r[k]) << 1) + NUMW'(adet10_r);
      end
      den11_r     <= {adet10_r, 1'b0};
      tl11_r.sd   <= sd10_r;
      tl11_r.neg  <= neg10_r;
      tl11_r.sing <= (adet10_r == '0) || (adet10_r < (DW'(thr_sing_r) << F));
    end
  end

  // Quotient pipelines
  logic [QB-1:0] quo [3];
  logic [2:0]    ovf;

  for (genvar k = 0; k < 3; k++) begin : g_div
    ppil_div #(.NUMW(NUMW), .DENW(DENW), .QB(QB)) u_div (
      .clk(clk), .en(en), .num(num11_r[k]), .den(den11_r),
      .quo(quo[k]), .ovf(ovf[k])
    );
  end

  // Delay side data alongside the quotient pipelines
  tail_t tl_r [LD];

  always_ff @(posedge clk) begin
    if (en) begin
      tl_r[0] <= tl11_r;
      for (int i = 1; i < LD; i++) tl_r[i] <= tl_r[i-1];
    end
  end

  // Assemble the result
  tail_t              tl_end;
  logic               pt_ok;
  logic signed [31:0] pt [3];
  ppil_pkg::out_t     res;

  assign tl_end = tl_r[LD-1];
  assign pt_ok  = !tl_end.sd.par && tl_end.sd.want && !tl_end.sing;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!pt_ok) begin
        pt[k] = '0;
      end else if (ovf[k]) begin
        pt[k] = tl_end.neg[k] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        pt[k] = tl_end.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
      end
    end
    if (tl_end.sd.par) begin
      res.status = ppil_pkg::ST_PARALLEL;
    end else if (tl_end.sd.want && tl_end.sing) begin
      res.status = ppil_pkg::ST_SINGULAR;
    end else begin
      res.status = ppil_pkg::ST_INTERSECT;
    end
    res.dir_x   = tl_end.sd.dir[0];
    res.dir_y   = tl_end.sd.dir[1];
    res.dir_z   = tl_end.sd.dir[2];
    res.point_x = pt[0];
    res.point_y = pt[1];
    res.point_z = pt[2];
  end

  // Two-entry output buffer
  ppil_pkg::out_t ent0_r, ent1_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  assign en        = (cnt_r != 2'd2);
  assign in_ready  = en;
  assign push      = en && vt_r[LD-1];
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = ent0_r;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))) begin
      ent0_r <= res;
    end else if (pop && (cnt_r == 2'd2)) begin
      ent0_r <= ent1_r;
    end
    if (push && (cnt_r == 2'd1) && !pop) begin
      ent1_r <= res;
    end
  end

`ifndef SYNTH
  // Buffer never holds more than two results
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("output buffer count out of range");

  // A result with no line carries a zero point
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ppil_pkg::ST_INTERSECT) |->
      (out_data.point_x == '0) && (out_data.point_y == '0) &&
      (out_data.point_z == '0))
    else $error("point not zero for parallel or singular result");

  // Full and stalled buffer holds its head
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && !out_ready |=> (cnt_r == 2'd2) && $stable(out_data))
    else $error("full output buffer changed while stalled");
`endif

endmodule

// ----- tb/sv/plane_plane_intersection_line_tb.sv -----
// ----------------------------------------------------------------------------
// plane_plane_intersection_line_tb: self-checking bench for the plane pair block
// Walks a table of directed plane pairs, then random pairs over several threshold
// settings and idle patterns. Every result is checked against a fixed-point
// predictor of direction, status and point.
// ----------------------------------------------------------------------------
module plane_plane_intersection_line_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  localparam int Q = 65536;
  localparam int MAXV = 32'sh7fffffff;
  localparam int MINV = 32'sh80000000;
  localparam logic [30:0] THR_MAX = 31'h7fffffff;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 200;

  // One directed row: thresholds to run under, request, optional typed result
  typedef struct {
    logic [30:0]    pthr;
    logic [30:0]    sthr;
    ppil_pkg::in_t  req;
    bit             typed;
    ppil_pkg::out_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ppil_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  ppil_pkg::out_t out_data;
  logic cfg_we;
  logic [ppil_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ppil_pkg::CFG_DATA_W-1:0] cfg_wdata;

  logic [30:0] par_thr;
  logic [30:0] sing_thr;
  ppil_pkg::out_t line_q[$];
  row_t rows[$];
  int errors;
  int cycles;
  int send_gap_pct;
  int stall_pct;

  plane_plane_intersection_line uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > $signed(256'h7fffffff)) return MAXV;
    if (v < -$signed(256'h80000000)) return MINV;
    return v[31:0];
  endfunction

  // Add half an LSB, then floor-shift down by the fraction width
  function automatic wide_t round_frac(wide_t v);
    return (v + wide_t'(32768)) >>> 16;
  endfunction

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Compute direction, status and point for one plane pair
  function automatic ppil_pkg::out_t predict_line(ppil_pkg::in_t x);
    wide_t a[3], b[3], c[3];
    wide_t da, db, sq, dv, s00, s01, s11, n00, n01, n11, det, mdet, p, mn, md, q;
    logic signed [31:0] dir[3];
    ppil_pkg::out_t r;
    a[0] = x.first_nx;  a[1] = x.first_ny;  a[2] = x.first_nz;
    b[0] = x.second_nx; b[1] = x.second_ny; b[2] = x.second_nz;
    da = x.first_offset;
    db = x.second_offset;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      dir[k] = sat32(round_frac(c[k]));
      dv = dir[k];
      sq = sq + wabs(dv) * wabs(dv);
    end
    r.status = ppil_pkg::ST_INTERSECT;
    r.dir_x = dir[0];
    r.dir_y = dir[1];
    r.dir_z = dir[2];
    r.point_x = 0;
    r.point_y = 0;
    r.point_z = 0;
    if (sq < (wide_t'(par_thr) << 16)) begin
      r.status = ppil_pkg::ST_PARALLEL;
      return r;
    end
    if (!x.want_line) return r;
    s00 = 0;
    s01 = 0;
    s11 = 0;
    for (int k = 0; k < 3; k++) begin
      s00 = s00 + a[k] * a[k];
      s01 = s01 + a[k] * b[k];
      s11 = s11 + b[k] * b[k];
    end
    n00 = round_frac(s00);
    n01 = round_frac(s01);
    n11 = round_frac(s11);
    det = n00 * n11 - n01 * n01;
    mdet = wabs(det);
    // zero determinant is singular whatever the threshold
    if (mdet == 0 || mdet < (wide_t'(sing_thr) << 16)) begin
      r.status = ppil_pkg::ST_SINGULAR;
      return r;
    end
    md = wabs(det);
    for (int k = 0; k < 3; k++) begin
      p = n01 * (db * a[k] + da * b[k]) - n11 * (da * a[k]) - n00 * (db * b[k]);
      mn = wabs(p);
      q = (2 * mn + md) / (2 * md);
      if ((p < 0) != (det < 0)) q = -q;
      case (k)
        0: r.point_x = sat32(q);
        1: r.point_y = sat32(q);
        default: r.point_z = sat32(q);
      endcase
    end
    return r;
  endfunction

  function automatic ppil_pkg::in_t mk_in(int nx, int ny, int nz, int d1,
                                          int mx, int my, int mz, int d2, bit wl);
    ppil_pkg::in_t x;
    x.first_nx = nx;  x.first_ny = ny;  x.first_nz = nz;  x.first_offset = d1;
    x.second_nx = mx; x.second_ny = my; x.second_nz = mz; x.second_offset = d2;
    x.want_line = wl;
    return x;
  endfunction

  function automatic ppil_pkg::out_t mk_out(ppil_pkg::status_t st, int dx, int dy,
                                            int dz, int px, int py, int pz);
    ppil_pkg::out_t r;
    r.status = st;
    r.dir_x = dx;   r.dir_y = dy;   r.dir_z = dz;
    r.point_x = px; r.point_y = py; r.point_z = pz;
    return r;
  endfunction

  function automatic void add_row(logic [30:0] pt, logic [30:0] st, ppil_pkg::in_t x,
                                  bit typed, ppil_pkg::out_t r);
    row_t w;
    w.pthr = pt;
    w.sthr = st;
    w.req = x;
    w.typed = typed;
    w.res = r;
    rows.push_back(w);
  endfunction

  function automatic int srand(int range);
    return int'($urandom_range(0, 2 * range)) - range;
  endfunction

  // Random plane pair: mostly well-scaled, some parallel, near-parallel, tiny or raw
  function automatic ppil_pkg::in_t rand_pair();
    ppil_pkg::in_t x;
    int kind;
    int s;
    kind = $urandom_range(0, 9);
    x = mk_in(srand(1 << 17), srand(1 << 17), srand(1 << 17), srand(1 << 20),
              srand(1 << 17), srand(1 << 17), srand(1 << 17), srand(1 << 20),
              $urandom_range(0, 3) != 0);
    if (kind == 0) begin
      x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, 1'($urandom)};
    end else if (kind == 1) begin
      s = srand(2);
      x.second_nx = x.first_nx * s;
      x.second_ny = x.first_ny * s;
      x.second_nz = x.first_nz * s;
    end else if (kind == 2) begin
      x.first_nx = srand(4);  x.first_ny = srand(4);  x.first_nz = srand(4);
      x.second_nx = srand(4); x.second_ny = srand(4); x.second_nz = srand(4);
    end else if (kind == 3) begin
      x.second_nx = x.first_nx + srand(8);
      x.second_ny = x.first_ny + srand(8);
      x.second_nz = x.first_nz + srand(8);
    end
    return x;
  endfunction

  task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Track accepted requests and check each result against the oldest one
  always @(posedge clk) begin
    ppil_pkg::out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) line_q.push_back(predict_line(in_data));
      if (out_valid && out_ready) begin
        if (line_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time, out_data);
          errors++;
        end else begin
          e = line_q.pop_front();
          cmp_field("status", 32'(e.status), 32'(out_data.status));
          cmp_field("dir_x", e.dir_x, out_data.dir_x);
          cmp_field("dir_y", e.dir_y, out_data.dir_y);
          cmp_field("dir_z", e.dir_z, out_data.dir_z);
          cmp_field("point_x", e.point_x, out_data.point_x);
          cmp_field("point_y", e.point_y, out_data.point_y);
          cmp_field("point_z", e.point_z, out_data.point_z);
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("plane_plane_intersection_line verification failed");
      $finish;
    end
  end

  // Offer one request, with a random gap first, and hold until accepted
  task automatic send(ppil_pkg::in_t x);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait out every outstanding result plus pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_thr(logic [30:0] pt, logic [30:0] st);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= ppil_pkg::REG_PARALLEL_THR;
    cfg_wdata <= pt;
    @(posedge clk);
    cfg_index <= ppil_pkg::REG_SINGULAR_THR;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_we <= 1'b0;
    par_thr = pt;
    sing_thr = st;
    @(posedge clk);
  endtask

  initial begin
    logic [30:0] ph_p[6];
    logic [30:0] ph_s[6];
    row_t w;
    ppil_pkg::out_t z;
    errors = 0;
    cycles = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    par_thr = ppil_pkg::THR_RESET;
    sing_thr = ppil_pkg::THR_RESET;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= ppil_pkg::REG_PARALLEL_THR;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    z = mk_out(ppil_pkg::ST_INTERSECT, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, mk_in(0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
            mk_out(ppil_pkg::ST_PARALLEL, 0, 0, 0, 0, 0, 0));
    add_row(1, 1, mk_in(Q, 0, 0, Q, 0, Q, 0, 2 * Q, 0), 1,
            mk_out(ppil_pkg::ST_INTERSECT, 0, 0, Q, 0, 0, 0));
    add_row(1, 1, mk_in(Q, 0, 0, Q, 0, Q, 0, 2 * Q, 1), 1,
            mk_out(ppil_pkg::ST_INTERSECT, 0, 0, Q, -Q, -2 * Q, 0));
    add_row(1, 1, mk_in(Q, Q, Q, 5, Q, Q, Q, -7, 1), 1,
            mk_out(ppil_pkg::ST_PARALLEL, 0, 0, 0, 0, 0, 0));
    add_row(1, 1, mk_in(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1), 1,
            mk_out(ppil_pkg::ST_PARALLEL, 0, 0, 0, 0, 0, 0));
    add_row(1, 1, mk_in(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1), 1,
            mk_out(ppil_pkg::ST_PARALLEL, 0, 0, 0, 0, 0, 0));
    add_row(1, 1, mk_in(MAXV, 0, 0, MAXV, 0, MINV, 0, MINV, 1), 0, z);
    add_row(1, 1, mk_in(MINV, MAXV, MINV, MAXV, MAXV, MINV, 1, MINV, 1), 0, z);
    add_row(1, 1, mk_in(Q, 2 * Q, -Q, 3 * Q, -Q, Q, 4 * Q, -Q, 1), 0, z);
    add_row(1, 1, mk_in(Q, 0, 0, MINV, 0, 0, Q, MAXV, 1), 0, z);
    add_row(1, 1, mk_in(3, -2, 1, 9, 1, 4, -3, -6, 1), 0, z);
    add_row(0, 1000, mk_in(Q, 0, 0, Q, Q, 256, 0, Q, 1), 1,
            mk_out(ppil_pkg::ST_SINGULAR, 0, 0, 256, 0, 0, 0));
    add_row(0, 0, mk_in(1, 0, 0, Q, 0, 1, 0, Q, 1), 1,
            mk_out(ppil_pkg::ST_SINGULAR, 0, 0, 0, 0, 0, 0));
    add_row(0, 0, mk_in(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
    add_row(0, 0, mk_in(Q, 2 * Q, 3 * Q, -Q, 2 * Q, -Q, Q, Q, 1), 0, z);
    add_row(THR_MAX, THR_MAX, mk_in(Q, 0, 0, Q, 0, Q, 0, Q, 1), 1,
            mk_out(ppil_pkg::ST_PARALLEL, 0, 0, Q, 0, 0, 0));
    add_row(THR_MAX, THR_MAX, mk_in(MAXV, 0, 0, 0, 0, MAXV, 0, 0, 1), 0, z);

    foreach (rows[i]) begin
      w = rows[i];
      if (w.pthr != par_thr || w.sthr != sing_thr) write_thr(w.pthr, w.sthr);
      if (w.typed && predict_line(w.req) !== w.res) begin
        $display("%0t: table row %0d predictor expected %h actual %h",
                 $time, i, w.res, predict_line(w.req));
        errors++;
      end
      send(w.req);
    end

    // Random phases over threshold settings and idle patterns
    ph_p = '{1, 0, THR_MAX, 31'($urandom_range(0, 1 << 20)), 200, 1};
    ph_s = '{1, 0, THR_MAX, 31'($urandom_range(0, 1 << 20)), 0, 1};
    for (int ph = 0; ph < 6; ph++) begin
      write_thr(ph_p[ph], ph_s[ph]);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 21; stall_pct = 21; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // hold off until the pipeline is empty once per phase
        if (n == RANDOM_PER_PHASE / 2) drain();
        send(rand_pair());
      end
    end

    drain();
    if (errors == 0) begin
      $display("plane_plane_intersection_line verification clean");
    end else begin
      $display("plane_plane_intersection_line verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ppil_pkg.sv
hw/rtl/ppil_mul.sv
hw/rtl/ppil_div.sv
hw/rtl/plane_plane_intersection_line.sv
tb/sv/plane_plane_intersection_line_tb.sv
